// ----- rtl/lc3x_pkg.sv -----
// Shared types and constants for the LC-3 instruction execute block.
// No dependencies.
package lc3x_pkg;

  localparam int unsigned MemAddrBitsDef = 16;
  localparam logic [15:0] PcReset = 16'h3000;

  localparam logic [2:0] FlagN = 3'b100;
  localparam logic [2:0] FlagZ = 3'b010;
  localparam logic [2:0] FlagP = 3'b001;

  typedef enum logic [1:0] {
    OP_EXEC  = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    OPC_BR   = 4'h0,
    OPC_ADD  = 4'h1,
    OPC_LD   = 4'h2,
    OPC_ST   = 4'h3,
    OPC_JSR  = 4'h4,
    OPC_AND  = 4'h5,
    OPC_LDR  = 4'h6,
    OPC_STR  = 4'h7,
    OPC_RTI  = 4'h8,
    OPC_NOT  = 4'h9,
    OPC_LDI  = 4'hA,
    OPC_STI  = 4'hB,
    OPC_JMP  = 4'hC,
    OPC_RES  = 4'hD,
    OPC_LEA  = 4'hE,
    OPC_TRAP = 4'hF
  } opc_e;

  localparam logic [7:0] TrapGetc = 8'h20;
  localparam logic [7:0] TrapOut  = 8'h21;
  localparam logic [7:0] TrapIn   = 8'h23;
  localparam logic [7:0] TrapHalt = 8'h25;

  // Input word as carried on the input channel.
  typedef struct packed {
    op_e         op;
    logic [15:0] instruction;
    logic [15:0] mem_addr;
    logic [15:0] mem_data;
    logic [7:0]  char_in;
  } in_t;

  // Decoded word handed from the front end to the back end.
  typedef struct packed {
    op_e         op;
    opc_e        opc;
    logic [15:0] ins;
    logic [15:0] mem_addr;
    logic [15:0] mem_data;
    logic [7:0]  char_in;
  } dec_t;

  typedef struct packed {
    logic [15:0] pc_value;
    logic [15:0] read_data;
    logic [2:0]  cond_flags;
    logic [7:0]  char_out;
    logic        char_out_valid;
    logic        halted;
  } res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD1,
    ST_RD2,
    ST_WAIT,
    ST_DONE
  } st_e;

  function automatic logic [15:0] sext9(input logic [8:0] v);
    return {{7{v[8]}}, v};
  endfunction

  function automatic logic [15:0] sext6(input logic [5:0] v);
    return {{10{v[5]}}, v};
  endfunction

  function automatic logic [15:0] sext5(input logic [4:0] v);
    return {{11{v[4]}}, v};
  endfunction

  function automatic logic [15:0] sext11(input logic [10:0] v);
    return {{5{v[10]}}, v};
  endfunction

  function automatic logic [2:0] nzp(input logic [15:0] v);
    logic [2:0] f;
    if (v[15]) f = FlagN;
    else if (v == 16'd0) f = FlagZ;
    else f = FlagP;
    return f;
  endfunction

endpackage

// ----- rtl/lc3x_if.sv -----
// Valid/ready channel interface carrying one payload word.
// Depends on nothing; payload type is a parameter.
interface lc3x_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/lc3x_ram.sv -----
// Generic single-port RAM with registered read.
// No dependencies.
module lc3x_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end
endmodule

// ----- rtl/lc3x_front.sv -----
// Front end: accepts words, decodes opcode, pushes into a two-entry queue.
// Depends on lc3x_pkg.
module lc3x_front
  import lc3x_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  op_i,
  input  logic [15:0] instruction_i,
  input  logic [15:0] mem_addr_i,
  input  logic [15:0] mem_data_i,
  input  logic [7:0]  char_in_i,
  output logic        q_valid_o,
  input  logic        q_pop_i,
  output dec_t        q_data_o
);
  dec_t     buf_q [2];
  logic     wp_q, rp_q;
  logic [1:0] cnt_q;
  dec_t     din;
  logic     push;

  always_comb begin
    din.op       = op_e'(op_i);
    din.opc      = opc_e'(instruction_i[15:12]);
    din.ins      = instruction_i;
    din.mem_addr = mem_addr_i;
    din.mem_data = mem_data_i;
    din.char_in  = char_in_i;
  end

  assign in_ready_o = (cnt_q != 2'd2);
  assign push       = in_valid_i && in_ready_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_data_o   = buf_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wp_q] <= din;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (q_pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop_i};
    end
  end
endmodule

// ----- rtl/lc3x_back.sv -----
// Back end: executes decoded words against registers, flags and memory.
// Depends on lc3x_pkg and lc3x_ram.
module lc3x_back
  import lc3x_pkg::*;
#(
  parameter int unsigned MemAddrBits = MemAddrBitsDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic q_valid_i,
  output logic q_pop_o,
  input  dec_t q_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output res_t out_data_o
);
  st_e         st_q, st_d;
  logic [15:0] rf_q [8];
  logic [15:0] pc_q;
  logic [2:0]  fl_q;
  logic        halt_q;
  res_t        res_q;
  logic        ov_q;

  logic                   we;
  logic [MemAddrBits-1:0] maddr;
  logic [15:0]            mwdata, mrdata;
  logic [MemAddrBits-1:0] ld_addr_q;

  lc3x_ram #(.Width(16), .Depth(2 ** MemAddrBits)) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .addr_i (maddr),
    .wdata_i(mwdata),
    .rdata_o(mrdata)
  );

  dec_t        d;
  logic [2:0]  dr, sr1;
  logic [15:0] pc1, vs1, vb, vdr, ea9, ea6, alu;
  logic        ex;

  assign d   = q_data_i;
  assign dr  = d.ins[11:9];
  assign sr1 = d.ins[8:6];
  assign pc1 = pc_q + 16'd1;
  assign vs1 = rf_q[sr1];
  assign vdr = rf_q[dr];
  assign vb  = d.ins[5] ? sext5(d.ins[4:0]) : rf_q[d.ins[2:0]];
  assign ea9 = pc1 + sext9(d.ins[8:0]);
  assign ea6 = vs1 + sext6(d.ins[5:0]);
  assign ex  = (d.op == OP_EXEC) && !halt_q;

  always_comb begin
    unique case (d.opc)
      OPC_ADD: alu = vs1 + vb;
      OPC_AND: alu = vs1 & vb;
      OPC_NOT: alu = ~vs1;
      default: alu = ea9;
    endcase
  end

  logic        fire, needs_mem, out_free;
  logic        rf_we, fl_we;
  logic [2:0]  rf_wa;
  logic [15:0] rf_wd, pc_d;
  logic        halt_d, cov;
  logic [7:0]  co;
  logic [15:0] rd;

  assign out_free = !ov_q || out_ready_i;

  always_comb begin
    st_d    = st_q;
    q_pop_o = 1'b0;
    fire    = 1'b0;
    we      = 1'b0;
    maddr   = d.mem_addr[MemAddrBits-1:0];
    mwdata  = d.mem_data;
    rf_we   = 1'b0;
    fl_we   = 1'b0;
    rf_wa   = dr;
    rf_wd   = alu;
    pc_d    = pc_q;
    halt_d  = halt_q;
    cov     = 1'b0;
    co      = 8'd0;
    rd      = 16'd0;
    needs_mem = 1'b0;
    if (ex) begin
      unique case (d.opc)
        OPC_LD, OPC_LDI, OPC_LDR, OPC_STI: needs_mem = 1'b1;
        default: needs_mem = 1'b0;
      endcase
    end
    unique case (st_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          if (d.op == OP_READ) begin
            st_d = ST_RD1;
          end else if (needs_mem) begin
            maddr = (d.opc == OPC_LDR) ? ea6[MemAddrBits-1:0] : ea9[MemAddrBits-1:0];
            st_d  = ST_RD1;
          end else if (out_free) begin
            fire = 1'b1;
            if (d.op == OP_WRITE) begin
              we = 1'b1;
            end else if (ex) begin
              pc_d = pc1;
              unique case (d.opc)
                OPC_ADD, OPC_AND, OPC_NOT, OPC_LEA: begin
                  rf_we = 1'b1;
                  fl_we = 1'b1;
                end
                OPC_BR: if ((dr & fl_q) != 3'd0) pc_d = ea9;
                OPC_JMP: pc_d = vs1;
                OPC_JSR: begin
                  pc_d  = d.ins[11] ? pc1 + sext11(d.ins[10:0]) : vs1;
                  rf_we = 1'b1;
                  rf_wa = 3'd7;
                  rf_wd = pc1;
                end
                OPC_ST: begin
                  we     = 1'b1;
                  maddr  = ea9[MemAddrBits-1:0];
                  mwdata = vdr;
                end
                OPC_STR: begin
                  we     = 1'b1;
                  maddr  = ea6[MemAddrBits-1:0];
                  mwdata = vdr;
                end
                OPC_TRAP: begin
                  if (d.ins[7:0] == TrapGetc || d.ins[7:0] == TrapIn) begin
                    rf_we = 1'b1;
                    rf_wa = 3'd0;
                    rf_wd = {8'd0, d.char_in};
                  end else if (d.ins[7:0] == TrapOut) begin
                    cov = 1'b1;
                    co  = rf_q[0][7:0];
                  end else if (d.ins[7:0] == TrapHalt) begin
                    halt_d = 1'b1;
                  end
                end
                default: ;
              endcase
            end
          end
        end
      end
      ST_RD1: begin
        // first read data available
        if (d.op == OP_READ) begin
          if (out_free) begin
            fire = 1'b1;
            rd   = mrdata;
            st_d = ST_IDLE;
          end else begin
            st_d = ST_WAIT;
          end
        end else if (d.opc == OPC_LDI || d.opc == OPC_STI) begin
          maddr = mrdata[MemAddrBits-1:0];
          if (d.opc == OPC_STI) begin
            if (out_free) begin
              fire   = 1'b1;
              we     = 1'b1;
              mwdata = vdr;
              pc_d   = pc1;
              st_d   = ST_IDLE;
            end else begin
              st_d = ST_WAIT;
            end
          end else begin
            st_d = ST_RD2;
          end
        end else begin
          st_d = ST_RD2;
        end
      end
      ST_RD2: begin
        // for LD/LDR data held in RAM output reg again by same address re-read
        st_d = ST_DONE;
      end
      ST_WAIT: begin
        // replay the first read
        maddr = (d.op == OP_READ) ? d.mem_addr[MemAddrBits-1:0] : ea9[MemAddrBits-1:0];
        st_d  = ST_RD1;
      end
      ST_DONE: begin
        if (out_free) begin
          fire  = 1'b1;
          pc_d  = pc1;
          rf_we = 1'b1;
          fl_we = 1'b1;
          rf_wd = mrdata;
          st_d  = ST_IDLE;
        end
        maddr = ld_addr_q;
      end
      default: st_d = ST_IDLE;
    endcase
    if (st_q == ST_RD1 && st_d == ST_RD2) begin
      // keep address for LD/LDR; LDI already pointer
      if (d.opc == OPC_LD) maddr = ea9[MemAddrBits-1:0];
      else if (d.opc == OPC_LDR) maddr = ea6[MemAddrBits-1:0];
    end
    if (st_q == ST_RD2) maddr = ld_addr_q;
    q_pop_o = fire;
  end

  always_ff @(posedge clk_i) begin
    if (st_q == ST_RD1 || st_q == ST_RD2) ld_addr_q <= maddr;
    if (fire) begin
      res_q.pc_value       <= pc_d;
      res_q.read_data      <= rd;
      res_q.cond_flags     <= fl_we ? nzp(rf_wd) : fl_q;
      res_q.char_out       <= co;
      res_q.char_out_valid <= cov;
      res_q.halted         <= halt_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= ST_IDLE;
      pc_q   <= PcReset;
      fl_q   <= FlagZ;
      halt_q <= 1'b0;
      ov_q   <= 1'b0;
      for (int i = 0; i < 8; i++) rf_q[i] <= 16'd0;
    end else begin
      st_q   <= st_d;
      pc_q   <= pc_d;
      halt_q <= halt_d;
      if (fl_we) fl_q <= nzp(rf_wd);
      if (rf_we) rf_q[rf_wa] <= rf_wd;
      if (fire) ov_q <= 1'b1;
      else if (out_ready_i) ov_q <= 1'b0;
    end
  end

  assign out_valid_o = ov_q;
  assign out_data_o  = res_q;
endmodule

// ----- rtl/lc3_instruction_execute.sv -----
// LC-3 instruction execute block, top level.
// Depends on lc3x_pkg, lc3x_if, lc3x_front, lc3x_back, lc3x_ram.
//
// Usage: in_if carries one word per instruction, memory preload or
// memory readback; out_if returns exactly one result word per input word,
// in order. Valid/ready on both sides; a word moves when both are high.
// The front end queues up to two words, so input is taken while a result
// waits in the output register. Register, branch, jump, store, trap and
// no-op words and preloads finish straight from the idle state; readback
// and STI also pass the first-read state; LD, LDR and LDI pass the
// first-read, second-read and done states, set by the single RAM port and
// its registered read. The result is registered and valid the cycle after
// the back end finishes. Reset clears registers to zero, PC to 0x3000,
// flags to Z and the halt flag; memory is undefined until written and
// needs no clearing pass. A stalled receiver holds the result and the back
// end waits; a readback or STI caught by a stall re-issues its first read
// through the wait state. The queue then fills and in ready drops.
module lc3_instruction_execute
  import lc3x_pkg::*;
#(
  parameter int unsigned MemAddrBits = MemAddrBitsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  lc3x_if.sink       in_if,
  lc3x_if.source     out_if
);
  logic q_valid, q_pop;
  dec_t q_data;
  in_t  in_w;
  res_t out_w;

  assign in_w = in_if.data;

  lc3x_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_if.valid),
    .in_ready_o   (in_if.ready),
    .op_i         (in_w.op),
    .instruction_i(in_w.instruction),
    .mem_addr_i   (in_w.mem_addr),
    .mem_data_i   (in_w.mem_data),
    .char_in_i    (in_w.char_in),
    .q_valid_o    (q_valid),
    .q_pop_i      (q_pop),
    .q_data_o     (q_data)
  );

  lc3x_back #(.MemAddrBits(MemAddrBits)) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_pop_o    (q_pop),
    .q_data_i   (q_data),
    .out_valid_o(out_if.valid),
    .out_ready_i(out_if.ready),
    .out_data_o (out_w)
  );

  assign out_if.data = out_w;

  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid) else $error("pop from empty queue");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && !out_if.ready |=> out_if.valid) else $error("result lost");

  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && out_if.data.halted |=> !out_if.valid || out_if.data.halted)
    else $error("halt cleared");
endmodule
